// ===== design/mu8d_pkg.sv =====
// Shared types, status codes and the UTF-8 encode function for the
// modified UTF-8 string decoder. No dependencies.
package mu8d_pkg;

	localparam int RUN_MAX = 6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PAST_LEN = 3'd1;
	localparam logic [2:0] ST_BAD_CONT = 3'd2;
	localparam logic [2:0] ST_OVERLONG = 3'd3;
	localparam logic [2:0] ST_BAD_LEAD = 3'd4;
	localparam logic [2:0] ST_EARLY    = 3'd5;

	// All results caused by one input byte: a list of UTF-8 bytes, then
	// optionally one status result with no byte.
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [2:0]              nbytes;
		logic                    tail;
		logic [2:0]              status;
		logic                    done;
	} run_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} cp_enc_t;

	function automatic cp_enc_t encode_cp(input logic [20:0] cp);
		cp_enc_t e;
		e = '0;
		if (cp <= 21'h7f) begin
			e.b[0] = cp[7:0];
			e.n    = 3'd1;
		end else if (cp <= 21'h7ff) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.n    = 3'd2;
		end else if (cp <= 21'hffff) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.n    = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.n    = 3'd4;
		end
		return e;
	endfunction

endpackage

// ===== design/mu8d_in_if.sv =====
// Input byte channel: valid/ready handshake with the raw byte and the
// end-of-stream mark. No dependencies.
interface mu8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

// ===== design/mu8d_out_if.sv =====
// Result channel: valid/ready handshake with one decoded result per request.
// No dependencies.
interface mu8d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [2:0] status;
	logic       string_done;
	logic       last_of_run;

	modport source (output valid, output out_byte, output byte_valid, output status,
		output string_done, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input status,
		input string_done, input last_of_run, output ready);
endinterface

// ===== design/mu8d_front.sv =====
// Front end: accepts input bytes, tracks string framing and unit decoding,
// and builds one run of results per byte. Depends on mu8d_pkg, mu8d_in_if.
module mu8d_front import mu8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mu8d_in_if.sink     byte_in,
	input  logic        full,
	output logic        push,
	output run_t        run
);

	localparam logic [1:0] PH_LEN_HI   = 2'd0;
	localparam logic [1:0] PH_LEN_LO   = 2'd1;
	localparam logic [1:0] PH_PAYLOAD  = 2'd2;
	localparam logic [1:0] PH_UNUSED   = 2'd3;

	logic [1:0]  phase_q, phase_n;
	logic [7:0]  len_hi_q, len_hi_n;
	logic [15:0] remain_q, remain_n;
	logic [1:0]  cont_q, cont_n;
	logic [1:0]  seq_q, seq_n;
	logic [15:0] partial_q, partial_n;
	logic [9:0]  held_q, held_n;
	logic        held_v_q, held_v_n;
	logic        skip_q, skip_n;

	logic        accept;
	logic [7:0]  b;
	logic [15:0] len, rem, u;
	logic [2:0]  st;
	logic        have, pair;
	logic        a_v, b_v;
	logic [20:0] cp_b;
	cp_enc_t     enc_a, enc_b;
	logic [2:0]  na, nb, ib;
	logic        run_tail, run_done;
	logic [2:0]  run_status;

	assign byte_in.ready = !full;
	assign accept        = byte_in.valid && !full;
	assign b             = byte_in.data_byte;
	assign len           = {len_hi_q, b};
	assign rem           = remain_q - 16'd1;

	always_comb begin
		phase_n   = phase_q;
		len_hi_n  = len_hi_q;
		remain_n  = remain_q;
		cont_n    = cont_q;
		seq_n     = seq_q;
		partial_n = partial_q;
		held_n    = held_q;
		held_v_n  = held_v_q;
		skip_n    = skip_q;
		st        = ST_OK;
		have      = 1'b0;
		pair      = 1'b0;
		u         = '0;
		a_v       = 1'b0;
		b_v       = 1'b0;
		cp_b      = '0;
		run_tail   = 1'b0;
		run_status = ST_OK;
		run_done   = 1'b0;

		unique case (phase_q)
			PH_LEN_LO: begin
				cont_n   = '0;
				held_v_n = 1'b0;
				skip_n   = 1'b0;
				if (len == 16'd0) begin
					run_tail = 1'b1;
					run_done = 1'b1;
					phase_n  = PH_LEN_HI;
				end else begin
					remain_n = len;
					phase_n  = PH_PAYLOAD;
					if (byte_in.stream_end) begin
						run_tail   = 1'b1;
						run_status = ST_EARLY;
						run_done   = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				remain_n = rem;
				if (skip_q) begin
					if (rem == 16'd0) begin
						skip_n  = 1'b0;
						phase_n = PH_LEN_HI;
					end
				end else begin
					// Classify the byte against the unit in progress.
					if (cont_q == 2'd0) begin
						if (b != 8'h00 && b < 8'h80) begin
							u    = {8'h00, b};
							have = 1'b1;
						end else if (b[7:5] == 3'b110) begin
							if (rem < 16'd1) begin
								st = ST_PAST_LEN;
							end else begin
								partial_n = {5'b0, b[4:0], 6'b0};
								cont_n    = 2'd1;
								seq_n     = 2'd2;
							end
						end else if (b[7:4] == 4'b1110) begin
							if (rem < 16'd2) begin
								st = ST_PAST_LEN;
							end else begin
								partial_n = {b[3:0], 12'b0};
								cont_n    = 2'd2;
								seq_n     = 2'd3;
							end
						end else begin
							st = ST_BAD_LEAD;
						end
					end else if (b[7:6] != 2'b10) begin
						st = ST_BAD_CONT;
					end else if (cont_q == 2'd2) begin
						partial_n = partial_q | {4'b0, b[5:0], 6'b0};
						cont_n    = 2'd1;
					end else begin
						u      = partial_q | {10'b0, b[5:0]};
						cont_n = 2'd0;
						if (seq_q == 2'd3) begin
							if (u < 16'h0800)
								st = ST_OVERLONG;
						end else if (u != 16'd0 && u < 16'h0080) begin
							st = ST_OVERLONG;
						end
						if (st == ST_OK)
							have = 1'b1;
					end

					if (st != ST_OK) begin
						// Report, drop any held surrogate, skip the rest.
						run_tail   = 1'b1;
						run_status = st;
						run_done   = 1'b1;
						held_v_n   = 1'b0;
						cont_n     = '0;
						if (rem == 16'd0)
							phase_n = PH_LEN_HI;
						else
							skip_n = 1'b1;
					end else if (byte_in.stream_end && rem != 16'd0) begin
						run_tail   = 1'b1;
						run_status = ST_EARLY;
						run_done   = 1'b1;
					end else begin
						pair = have && held_v_q && u >= 16'hdc00 && u <= 16'hdfff;
						if (pair) begin
							cp_b     = 21'h10000 + {1'b0, held_q, 10'b0} + {11'b0, u[9:0]};
							b_v      = 1'b1;
							held_v_n = 1'b0;
						end else if (have) begin
							a_v = held_v_q;
							if (u >= 16'hd800 && u <= 16'hdbff) begin
								held_n   = u[9:0];
								held_v_n = 1'b1;
							end else begin
								cp_b     = {5'b0, u};
								b_v      = 1'b1;
								held_v_n = 1'b0;
							end
						end
						if (rem == 16'd0) begin
							// Flush a surrogate still held at string end.
							if (held_v_n) begin
								cp_b = {5'b0, 6'b110110, held_n};
								b_v  = 1'b1;
							end
							held_v_n = 1'b0;
							run_done = 1'b1;
							run_tail = !a_v && !b_v;
							cont_n   = '0;
							phase_n  = PH_LEN_HI;
						end
					end
				end
			end
			PH_LEN_HI, PH_UNUSED: begin
				len_hi_n = b;
				phase_n  = PH_LEN_LO;
				if (byte_in.stream_end) begin
					run_tail   = 1'b1;
					run_status = ST_EARLY;
					run_done   = 1'b1;
				end
			end
			default: phase_n = PH_LEN_HI;
		endcase

		if (byte_in.stream_end) begin
			phase_n   = PH_LEN_HI;
			len_hi_n  = '0;
			remain_n  = '0;
			cont_n    = '0;
			seq_n     = '0;
			partial_n = '0;
			held_n    = '0;
			held_v_n  = 1'b0;
			skip_n    = 1'b0;
		end
	end

	// Assemble the byte list: flushed surrogate first, then the new code point.
	assign enc_a = encode_cp({5'b0, 6'b110110, held_q});
	assign enc_b = encode_cp(cp_b);
	assign na    = a_v ? enc_a.n : 3'd0;
	assign nb    = b_v ? enc_b.n : 3'd0;

	always_comb begin
		run.tail   = run_tail;
		run.status = run_status;
		run.done   = run_done;
		run.nbytes = na + nb;
		for (int i = 0; i < RUN_MAX; i++) begin
			ib = 3'(i) - na;
			if (3'(i) < na)
				run.bytes[i] = enc_a.b[i[1:0]];
			else if (ib < 3'd4)
				run.bytes[i] = enc_b.b[ib[1:0]];
			else
				run.bytes[i] = 8'h00;
		end
	end

	assign push = accept && (run.tail || run.nbytes != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN_HI;
			len_hi_q  <= '0;
			remain_q  <= '0;
			cont_q    <= '0;
			seq_q     <= '0;
			partial_q <= '0;
			held_q    <= '0;
			held_v_q  <= 1'b0;
			skip_q    <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			len_hi_q  <= len_hi_n;
			remain_q  <= remain_n;
			cont_q    <= cont_n;
			seq_q     <= seq_n;
			partial_q <= partial_n;
			held_q    <= held_n;
			held_v_q  <= held_v_n;
			skip_q    <= skip_n;
		end
	end

endmodule

// ===== design/mu8d_queue.sv =====
// Four-entry queue of result runs between front and back end.
// Depends on mu8d_pkg.
module mu8d_queue import mu8d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t wdata,
	input  logic pop,
	output logic full,
	output logic empty,
	output run_t head
);

	localparam int DEPTH = 4;

	run_t       mem_q [DEPTH];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] count_q;

	assign full  = count_q == 3'(DEPTH);
	assign empty = count_q == 3'd0;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 2'd1;
			if (pop)
				rptr_q <= rptr_q + 2'd1;
			if (push && !pop)
				count_q <= count_q + 3'd1;
			else if (pop && !push)
				count_q <= count_q - 3'd1;
		end
	end

endmodule

// ===== design/mu8d_back.sv =====
// Back end: walks the run at the queue head and issues one result per
// request into the output register. Depends on mu8d_pkg, mu8d_out_if.
module mu8d_back import mu8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  run_t        head,
	input  logic        empty,
	output logic        pop,
	mu8d_out_if.source  results
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       in_bytes, last, issue;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       bv_q, done_q, last_q;
	logic [2:0] st_q;

	assign total    = head.nbytes + {2'b0, head.tail};
	assign in_bytes = idx_q < head.nbytes;
	assign last     = idx_q == total - 3'd1;
	assign issue    = !empty && (!ov_q || results.ready);
	assign pop      = issue && last;

	assign results.valid       = ov_q;
	assign results.out_byte    = byte_q;
	assign results.byte_valid  = bv_q;
	assign results.status      = st_q;
	assign results.string_done = done_q;
	assign results.last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (issue) begin
			last_q <= last;
			if (in_bytes) begin
				byte_q <= head.bytes[idx_q];
				bv_q   <= 1'b1;
				st_q   <= ST_OK;
				done_q <= head.done && !head.tail && last;
			end else begin
				byte_q <= 8'h00;
				bv_q   <= 1'b0;
				st_q   <= head.status;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (issue)
				ov_q <= 1'b1;
			else if (results.ready)
				ov_q <= 1'b0;
			if (issue)
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

// ===== design/modified_utf8_string_decoder.sv =====
// Top level of the modified UTF-8 string decoder: front end, run queue and
// back end. Depends on mu8d_pkg, mu8d_in_if, mu8d_out_if and the submodules.
//
// Usage:
//   bytes   - input channel, one raw byte per request: two length bytes
//             (big-endian), then the payload; stream_end marks the last byte
//             of the input and returns the front-end state to its reset value.
//   results - output channel, one result per request: a standard UTF-8 byte
//             (byte_valid high) or a status result (byte_valid low) that
//             closes a string; string_done marks the final result of a
//             string, last_of_run the final result caused by an input byte.
// A byte's first result goes through the run queue, then the output register.
// Throughput: one byte per cycle while each yields at most one result and no
// stall holds the output; a byte with k results (up to six, e.g. a flushed
// surrogate then a three-byte unit) holds the output while they issue from the
// single output register. The four-entry run queue absorbs the difference;
// bytes that yield nothing skip the queue, at full rate while it is not full.
// Reset: asynchronous, clears framing state, the queue and the output valid.
// Stall: while results.ready is low the output register holds its result,
// the queue fills, and bytes.ready drops once four runs wait.
module modified_utf8_string_decoder import mu8d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mu8d_in_if.sink    bytes,
	mu8d_out_if.source results
);

	logic push, pop, full, empty;
	run_t run, head;

	// Decode framing and units, one byte per accepted request.
	mu8d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (bytes),
		.full    (full),
		.push    (push),
		.run     (run)
	);

	// Hold runs so the front keeps accepting while results drain.
	mu8d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (run),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	// Serialize each run into result requests.
	mu8d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);

endmodule

// ===== design/mu8d_checker.sv =====
// Port-level checks on the decoder results, bound to the top level.
// Depends on mu8d_pkg.
module mu8d_checker import mu8d_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic [2:0] status,
	input logic       string_done,
	input logic       last_of_run
);

	// A status result always closes its string.
	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !byte_valid |-> string_done && last_of_run)
		else $error("status result without string_done or last_of_run");

	// A status result carries no byte.
	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !byte_valid |-> out_byte == 8'h00)
		else $error("status result with nonzero byte");

	// Data bytes always carry status ok.
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && byte_valid |-> status == ST_OK)
		else $error("data byte with error status");

	// Status stays within the defined codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> status <= ST_EARLY)
		else $error("status code out of range");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(status)
			&& $stable(byte_valid) && $stable(string_done) && $stable(last_of_run))
		else $error("result changed while stalled");

endmodule

bind modified_utf8_string_decoder mu8d_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (results.valid),
	.ready       (results.ready),
	.out_byte    (results.out_byte),
	.byte_valid  (results.byte_valid),
	.status      (results.status),
	.string_done (results.string_done),
	.last_of_run (results.last_of_run)
);
